// ===== rtl/ptlsm_pkg.sv =====
// shared types and constants for the tone table saturation matrix block
// no dependencies; used by pixel_tone_lut_saturation_matrix_top
`default_nettype none

package ptlsm_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned TONE_W    = 19;
  localparam int unsigned TONE_AW   = 8;
  localparam int unsigned TONE_DEPTH = 256;
  localparam int unsigned AWGT_W    = 13;
  localparam int unsigned XWGT_W    = 12;
  localparam int unsigned FRAC_BITS = 10;
  localparam int unsigned RES_W     = 16;
  localparam int unsigned APROD_W   = TONE_W + AWGT_W;
  localparam int unsigned XPROD_W   = TONE_W + XWGT_W;
  localparam int unsigned SUM_W     = APROD_W + 2;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // opcodes carried on in_tuser
  localparam logic OP_TABLE_WRITE = 1'b0;
  localparam logic OP_PIXEL       = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS_RED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS_GREEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS_BLUE   = 3'd5;

  localparam logic signed [AWGT_W-1:0] AWGT_RESET = 13'sd1024;
  localparam logic signed [XWGT_W-1:0] XWGT_RESET = 12'sd0;

  // side information that travels with a pixel down the pipe
  typedef struct packed {
    logic              clear;  // alpha is zero, colour forced to zero
    logic [CHAN_W-1:0] alpha;
    logic              last;
  } pix_meta_t;

endpackage

`default_nettype wire

// ===== rtl/pixel_tone_lut_saturation_matrix_top.sv =====
// tone table lookup plus 3x3 saturation matrix for rgba pixel streams
// depends on ptlsm_pkg (widths, opcodes, register indexes, pipe meta struct)
//
// usage
//   in_*   : stream of beats; in_tuser is the opcode. a table-write beat stores
//            table_value at table_index in the tone table and gives no result.
//            a pixel beat looks up red, green and blue in the table, runs the
//            three values through the weight matrix and gives one result beat.
//   out_*  : one beat per pixel; out_tlast copies the pixel's last mark
//   cfg_*  : register writes (six matrix weights), always ready; the user must
//            write only while the pipe is empty; the block does not enforce it
// throughput: one beat per cycle of any mix while the output is not stalled;
//   a table write may be followed by a pixel reading the same entry in the
//   next cycle, since the write lands at the accept edge, ahead of the read
// stages: three pipe registers (table read, the six multipliers, then sum,
//   clamp and the output register)
// stall: each stage holds while the next is full and stalled, so bubbles
//   close up; in_tready drops only once all three stages hold beats
// reset: rst_n clears the valid flags and restores the unit weights; the tone
//   table is not cleared and must be loaded before pixels use it
`default_nettype none

module pixel_tone_lut_saturation_matrix_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // slave side
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // [7:0] table_index, [26:8] table_value, [34:27] in_red, [42:35] in_green,
  // [50:43] in_blue, [58:51] in_alpha, [63:59] zero
  input  wire logic [ptlsm_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                               in_tuser,  // [0] opcode
  input  wire logic                               in_tlast,  // last_pixel
  // master side
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // [15:0] out_red, [31:16] out_green, [47:32] out_blue, [55:48] out_alpha
  output      logic [ptlsm_pkg::OUT_DATA_W-1:0]   out_tdata,
  output      logic                               out_tlast,
  // configuration writes
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [ptlsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ptlsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // input field unpacking
  logic [ptlsm_pkg::TONE_AW-1:0]       tbl_idx;
  logic signed [ptlsm_pkg::TONE_W-1:0] tbl_val;
  logic [ptlsm_pkg::CHAN_W-1:0]        in_red, in_green, in_blue, in_alpha;

  assign tbl_idx  = in_tdata[7:0];
  assign tbl_val  = in_tdata[26:8];
  assign in_red   = in_tdata[34:27];
  assign in_green = in_tdata[42:35];
  assign in_blue  = in_tdata[50:43];
  assign in_alpha = in_tdata[58:51];

  // stage enables: a stage loads when it is empty or its successor moves
  logic s1_v_r, s2_v_r, s3_v_r;
  logic en1, en2, en3;
  logic in_beat;

  assign en3       = !s3_v_r || out_tready;
  assign en2       = !s2_v_r || en3;
  assign en1       = !s1_v_r || en2;
  assign in_tready = en1;
  assign in_beat   = in_tvalid && in_tready;

  // weight registers
  logic signed [ptlsm_pkg::AWGT_W-1:0] w_ar_r, w_ag_r, w_ab_r;
  logic signed [ptlsm_pkg::XWGT_W-1:0] w_xr_r, w_xg_r, w_xb_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_ar_r <= ptlsm_pkg::AWGT_RESET;
      w_ag_r <= ptlsm_pkg::AWGT_RESET;
      w_ab_r <= ptlsm_pkg::AWGT_RESET;
      w_xr_r <= ptlsm_pkg::XWGT_RESET;
      w_xg_r <= ptlsm_pkg::XWGT_RESET;
      w_xb_r <= ptlsm_pkg::XWGT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptlsm_pkg::CFG_ACTIVE_RED:   w_ar_r <= cfg_data;
        ptlsm_pkg::CFG_ACTIVE_GREEN: w_ag_r <= cfg_data;
        ptlsm_pkg::CFG_ACTIVE_BLUE:  w_ab_r <= cfg_data;
        ptlsm_pkg::CFG_CROSS_RED:    w_xr_r <= cfg_data[ptlsm_pkg::XWGT_W-1:0];
        ptlsm_pkg::CFG_CROSS_GREEN:  w_xg_r <= cfg_data[ptlsm_pkg::XWGT_W-1:0];
        ptlsm_pkg::CFG_CROSS_BLUE:   w_xb_r <= cfg_data[ptlsm_pkg::XWGT_W-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // tone table: two copies written together; copy a serves red and green,
  // copy b serves blue, so every pixel gets its three reads in the same cycle
  logic signed [ptlsm_pkg::TONE_W-1:0] tone_a [ptlsm_pkg::TONE_DEPTH];
  logic signed [ptlsm_pkg::TONE_W-1:0] tone_b [ptlsm_pkg::TONE_DEPTH];
  logic signed [ptlsm_pkg::TONE_W-1:0] t_red_r, t_green_r, t_blue_r;
  logic tbl_we;

  assign tbl_we = in_beat && (in_tuser == ptlsm_pkg::OP_TABLE_WRITE);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tone_a[tbl_idx] <= tbl_val;
    end
    if (en1) begin
      t_red_r   <= tone_a[in_red];
      t_green_r <= tone_a[in_green];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tone_b[tbl_idx] <= tbl_val;
    end
    if (en1) begin
      t_blue_r <= tone_b[in_blue];
    end
  end

  // stage 1 control and meta
  ptlsm_pkg::pix_meta_t s1_meta_r, s1_meta_nxt;
  logic s1_v_nxt;

  assign s1_v_nxt          = in_beat && (in_tuser == ptlsm_pkg::OP_PIXEL);
  assign s1_meta_nxt.clear = (in_alpha == '0);
  assign s1_meta_nxt.alpha = in_alpha;
  assign s1_meta_nxt.last  = in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_meta_r <= s1_meta_nxt;
    end
  end

  // stage 2: six distinct products, the cross terms are shared by two rows
  logic signed [ptlsm_pkg::APROD_W-1:0] p_ar_r, p_ag_r, p_ab_r;
  logic signed [ptlsm_pkg::APROD_W-1:0] p_ar_nxt, p_ag_nxt, p_ab_nxt;
  logic signed [ptlsm_pkg::XPROD_W-1:0] p_xr_r, p_xg_r, p_xb_r;
  logic signed [ptlsm_pkg::XPROD_W-1:0] p_xr_nxt, p_xg_nxt, p_xb_nxt;
  ptlsm_pkg::pix_meta_t s2_meta_r;

  assign p_ar_nxt = w_ar_r * t_red_r;
  assign p_ag_nxt = w_ag_r * t_green_r;
  assign p_ab_nxt = w_ab_r * t_blue_r;
  assign p_xr_nxt = w_xr_r * t_red_r;
  assign p_xg_nxt = w_xg_r * t_green_r;
  assign p_xb_nxt = w_xb_r * t_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p_ar_r    <= p_ar_nxt;
      p_ag_r    <= p_ag_nxt;
      p_ab_r    <= p_ab_nxt;
      p_xr_r    <= p_xr_nxt;
      p_xg_r    <= p_xg_nxt;
      p_xb_r    <= p_xb_nxt;
      s2_meta_r <= s1_meta_r;
    end
  end

  // stage 3: row sums, clamp to 0 .. 0xffff<<10, drop the fraction
  logic signed [ptlsm_pkg::SUM_W-1:0] sum_red, sum_green, sum_blue;
  logic [ptlsm_pkg::RES_W-1:0] res_red, res_green, res_blue;
  logic [ptlsm_pkg::RES_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic [ptlsm_pkg::RES_W-1:0] out_red_nxt, out_green_nxt, out_blue_nxt;
  logic [ptlsm_pkg::CHAN_W-1:0] out_alpha_r;
  logic out_last_r;

  function automatic logic [ptlsm_pkg::RES_W-1:0] clamp_sum(
    input logic signed [ptlsm_pkg::SUM_W-1:0] s
  );
    logic [ptlsm_pkg::RES_W-1:0] q;
    q = s[ptlsm_pkg::FRAC_BITS +: ptlsm_pkg::RES_W];
    if (s[ptlsm_pkg::SUM_W-1]) begin
      q = '0;
    end else if (s[ptlsm_pkg::SUM_W-2:ptlsm_pkg::FRAC_BITS+ptlsm_pkg::RES_W] != '0) begin
      q = '1;
    end
    return q;
  endfunction

  assign sum_red   = ptlsm_pkg::SUM_W'(p_ar_r) + ptlsm_pkg::SUM_W'(p_xg_r)
                   + ptlsm_pkg::SUM_W'(p_xb_r);
  assign sum_green = ptlsm_pkg::SUM_W'(p_xr_r) + ptlsm_pkg::SUM_W'(p_ag_r)
                   + ptlsm_pkg::SUM_W'(p_xb_r);
  assign sum_blue  = ptlsm_pkg::SUM_W'(p_xr_r) + ptlsm_pkg::SUM_W'(p_xg_r)
                   + ptlsm_pkg::SUM_W'(p_ab_r);

  assign res_red   = clamp_sum(sum_red);
  assign res_green = clamp_sum(sum_green);
  assign res_blue  = clamp_sum(sum_blue);

  // transparent pixels come out all zero
  assign out_red_nxt   = s2_meta_r.clear ? '0 : res_red;
  assign out_green_nxt = s2_meta_r.clear ? '0 : res_green;
  assign out_blue_nxt  = s2_meta_r.clear ? '0 : res_blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_red_r   <= out_red_nxt;
      out_green_r <= out_green_nxt;
      out_blue_r  <= out_blue_nxt;
      out_alpha_r <= s2_meta_r.alpha;
      out_last_r  <= s2_meta_r.last;
    end
  end

  assign out_tvalid = s3_v_r;
  assign out_tdata  = {out_alpha_r, out_blue_r, out_green_r, out_red_r};
  assign out_tlast  = out_last_r;

  // checks

  // an empty output register never blocks the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !s3_v_r |-> in_tready)
    else $error("input stalled while output stage empty");

  // a table write never turns into a pipeline beat
  a_write_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ptlsm_pkg::OP_TABLE_WRITE) |=> !s1_v_r)
    else $error("table write entered the pixel pipe");

  // every accepted pixel occupies stage 1 next cycle
  a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ptlsm_pkg::OP_PIXEL) |=> s1_v_r)
    else $error("accepted pixel lost at stage 1");

  // a transparent result carries no colour
  a_clear_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[55:48] == '0) |-> (out_tdata[47:0] == '0))
    else $error("transparent pixel with nonzero colour");

endmodule

`default_nettype wire
